>>> rtl/pdl_pkg.sv
// Shared types and constants for the positional deque list.
`default_nettype none
package pdl_pkg;

  localparam int CAPACITY  = 16;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int DATA_W    = 32;
  localparam int OP_W      = 3;
  localparam int POS_W     = 5;
  localparam int STAT_W    = 2;
  localparam int OUT_CNT_W = 5;
  localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int IN_W      = 40;
  localparam int OUT_W     = 40;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_INSERT     = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4,
    OP_REMOVE     = 3'd5
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_INS  = 2'd1,
    CMD_DEL  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic             rem_valid;
    status_t          status;
    logic [CNT_W-1:0] count_next;
  } ctl_res_t;

  typedef struct packed {
    logic [OUT_CNT_W-1:0] count;
    status_t              status;
    logic                 removed_valid;
    logic [DATA_W-1:0]    removed_value;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/pdl_cell.sv
// One storage cell of the shifting element chain.
`default_nettype none
module pdl_cell
  import pdl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [IDX_W-1:0]  index,
  input  wire cmd_t              cmd,
  input  wire logic [DATA_W-1:0] left,
  input  wire logic [DATA_W-1:0] right,
  input  wire logic [DATA_W-1:0] rem_in,
  output logic [DATA_W-1:0]      rem_out,
  output logic [DATA_W-1:0]      data
);

  logic [DATA_W-1:0] data_next;

  always_comb begin
    data_next = data;
    case (cmd.kind)
      CMD_INS: begin
        if (index == cmd.idx) begin
          data_next = cmd.value;
        end else if (index > cmd.idx) begin
          data_next = left;
        end
      end
      CMD_DEL: begin
        if (index >= cmd.idx) begin
          data_next = right;
        end
      end
      default: data_next = data;
    endcase
  end

  // removed element rides the chain toward the front
  assign rem_out = (cmd.kind == CMD_DEL && index == cmd.idx) ? data : rem_in;

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule
`default_nettype wire

>>> rtl/pdl_ctrl.sv
// Operation decode: checks, chain command and new count.
`default_nettype none
module pdl_ctrl
  import pdl_pkg::*;
(
  input  wire op_t               op,
  input  wire logic [DATA_W-1:0] value,
  input  wire logic [POS_W-1:0]  position,
  input  wire logic [CNT_W-1:0]  count,
  output cmd_t                   cmd,
  output ctl_res_t               res
);

  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] cnt_x;
  logic             full;
  logic             empty;

  assign pos_x = CMP_W'(position);
  assign cnt_x = CMP_W'(count);
  assign full  = (count >= CNT_W'(CAPACITY));
  assign empty = (count == '0);

  always_comb begin
    cmd.kind       = CMD_NONE;
    cmd.idx        = '0;
    cmd.value      = value;
    res.rem_valid  = 1'b0;
    res.status     = ST_OK;
    res.count_next = count;
    unique case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
        if (full) begin
          res.status = ST_FULL;
        end else if (op == OP_INSERT && pos_x > cnt_x) begin
          res.status = ST_BADPOS;
        end else begin
          cmd.kind       = CMD_INS;
          res.count_next = count + CNT_W'(1);
          if (op == OP_PUSH_FRONT) begin
            cmd.idx = '0;
          end else if (op == OP_PUSH_BACK) begin
            cmd.idx = count[IDX_W-1:0];
          end else begin
            cmd.idx = IDX_W'(position);
          end
        end
      end
      OP_POP_FRONT, OP_POP_BACK, OP_REMOVE: begin
        if (empty) begin
          res.status = ST_EMPTY;
        end else if (op == OP_REMOVE && (pos_x == '0 || pos_x > cnt_x)) begin
          res.status = ST_BADPOS;
        end else begin
          cmd.kind       = CMD_DEL;
          res.rem_valid  = 1'b1;
          res.count_next = count - CNT_W'(1);
          if (op == OP_POP_FRONT) begin
            cmd.idx = '0;
          end else if (op == OP_POP_BACK) begin
            cmd.idx = IDX_W'(count - CNT_W'(1));
          end else begin
            cmd.idx = IDX_W'(position - POS_W'(1));
          end
        end
      end
      default: begin
        res.status = ST_OK;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/positional_deque_list.sv
// Top level: ordered list of values with deque and positional ops.
//
// Input stream (s_*): one item per operation: op, value, position packed
// in s_tdata. Output stream (m_*): one result item per accepted input:
// removed value, removed flag, status and new element count in m_tdata.
// Ops: push front, push back, insert after position (0 = front),
// pop front, pop back, remove 1-based position.
// Each result is registered in the output register. Throughput: one item
// per cycle while the skid register is empty; every cell of the element
// chain shifts left, right or holds in a single cycle, so the chain sets
// the rate. A skid register behind the output register keeps input
// accepted for one more item while the receiver stalls; s_tready drops
// once the skid register holds a result and rises as soon as it drains.
// Reset empties the list (count to zero) and drops both result registers;
// element cells are not cleared, slots past the count are never read.
`default_nettype none
module positional_deque_list
  import pdl_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [IN_W-1:0]  s_tdata,  // op[2:0], value[34:3], position[39:35]
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [OUT_W-1:0]      m_tdata   // removed_value[31:0], removed_valid[32],
                                          // status[34:33], count[39:35]
);

  logic              accept;
  logic [CNT_W-1:0]  count;
  cmd_t              cmd;
  cmd_t              cell_cmd;
  ctl_res_t          ctl;
  result_t           res;
  result_t           out_q;
  result_t           skid_q;
  logic              skid_valid;
  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] rem_chain [CAPACITY+1];

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;

  pdl_ctrl u_ctrl (
    .op       (op_t'(s_tdata[2:0])),
    .value    (s_tdata[34:3]),
    .position (s_tdata[39:35]),
    .count    (count),
    .cmd      (cmd),
    .res      (ctl)
  );

  always_comb begin
    cell_cmd = cmd;
    if (!accept) begin
      cell_cmd.kind = CMD_NONE;
    end
  end

  assign rem_chain[CAPACITY] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_d;
    logic [DATA_W-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end
    pdl_cell u_cell (
      .clk     (clk),
      .index   (IDX_W'(i)),
      .cmd     (cell_cmd),
      .left    (left_d),
      .right   (right_d),
      .rem_in  (rem_chain[i+1]),
      .rem_out (rem_chain[i]),
      .data    (cell_data[i])
    );
  end

  always_comb begin
    res.count         = OUT_CNT_W'(ctl.count_next);
    res.status        = ctl.status;
    res.removed_valid = ctl.rem_valid;
    res.removed_value = ctl.rem_valid ? rem_chain[0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= ctl.count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tvalid && !m_tready) begin
      if (accept) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      m_tvalid   <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      m_tvalid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tvalid && !m_tready) begin
      if (accept) begin
        skid_q <= res;
      end
    end else if (skid_valid) begin
      out_q <= skid_q;
    end else if (accept) begin
      out_q <= res;
    end
  end

  assign m_tdata = OUT_W'(out_q);

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid register full while output register empty");

  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && count == CNT_W'(CAPACITY) &&
     (s_tdata[2:0] == OP_PUSH_FRONT || s_tdata[2:0] == OP_PUSH_BACK ||
      s_tdata[2:0] == OP_INSERT)) |=> $stable(count))
    else $error("count changed on insert into full list");

  a_removed_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_q.removed_valid) |-> out_q.status == ST_OK)
    else $error("removed element with error status");

endmodule
`default_nettype wire
